FILE: hdl/bfr_pkg.sv
// Shared codes, constants and types of the binary frame receiver.
package bfr_pkg;

    localparam logic [1:0] ACT_RX    = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DROPPED  = 3'd1;
    localparam logic [2:0] EV_ACCEPTED = 3'd2;
    localparam logic [2:0] EV_BAD_END  = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;

    localparam logic [1:0] CFG_OPEN_BYTE  = 2'd0;
    localparam logic [1:0] CFG_CLOSE_BYTE = 2'd1;

    // Start flag plus two length bytes.
    localparam int HEADER_BYTES = 1 + 2;
    // Header plus the closing end flag.
    localparam int FRAME_OVERHEAD = 1 + 2 + 1;

    typedef struct packed {
        logic [2:0] event_res;
        logic       frame_ready;
        logic [7:0] payload_length;
        logic       read_hit;
    } t_meta;

endpackage

FILE: hdl/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bfr_ctrl.sv
// Framing control: flag registers, byte counter, bank select and frame store addressing.
module bfr_ctrl #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [1:0]                            i_action,
    input  logic [7:0]                            i_rx_byte,
    input  logic [7:0]                            i_read_index,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [7:0]                            i_cfg_data,
    output bfr_pkg::t_meta                        o_meta,
    output logic                                  o_wr_en,
    output logic [$clog2(2*BUFFER_BYTES)-1:0]     o_wr_addr,
    output logic [7:0]                            o_wr_data,
    output logic                                  o_rd_en,
    output logic [$clog2(2*BUFFER_BYTES)-1:0]     o_rd_addr
);
    import bfr_pkg::*;

    localparam int AW = $clog2(2 * BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES);

    logic [7:0]    r_open_byte;
    logic [7:0]    r_close_byte;
    logic          r_bank;
    logic          n_bank;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [15:0]   r_decl;
    logic [15:0]   n_decl;
    logic [CW-1:0] r_dlen;
    logic [CW-1:0] n_dlen;
    logic          r_new;
    logic          n_new;

    logic [CW:0]     cnt1;
    logic [16:0]     total;
    logic [16:0]     cnt1_ext;
    logic [CW+7:0]   idx_ext;
    logic [CW+7:0]   dlen_ext;
    logic [2:0]      ev;
    logic            hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_byte  <= '0;
            r_close_byte <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_OPEN_BYTE) begin
                r_open_byte <= i_cfg_data;
            end else if (i_cfg_index == CFG_CLOSE_BYTE) begin
                r_close_byte <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_decl  <= '0;
            r_dlen  <= '0;
            r_new   <= 1'b0;
        end else begin
            r_bank  <= n_bank;
            r_count <= n_count;
            r_decl  <= n_decl;
            r_dlen  <= n_dlen;
            r_new   <= n_new;
        end
    end

    assign idx_ext  = {{CW{1'b0}}, i_read_index};
    assign dlen_ext = {8'd0, r_dlen};
    assign cnt1     = {1'b0, r_count} + (CW+1)'(1);
    assign cnt1_ext = 17'(cnt1);
    assign total    = {1'b0, n_decl} + 17'(FRAME_OVERHEAD);

    always_comb begin
        n_bank  = r_bank;
        n_count = r_count;
        n_decl  = r_decl;
        n_dlen  = r_dlen;
        n_new   = r_new;
        ev      = EV_NONE;
        hit     = 1'b0;
        o_wr_en = 1'b0;
        if (i_accept) begin
            case (i_action)
                ACT_RX: begin
                    if (r_count == '0 && i_rx_byte != r_open_byte) begin
                        ev = EV_DROPPED;
                    end else begin
                        o_wr_en = 1'b1;
                        if (r_count == CW'(1)) begin
                            n_decl = {r_decl[15:8], i_rx_byte};
                        end else if (r_count == CW'(2)) begin
                            n_decl = {i_rx_byte, r_decl[7:0]};
                        end
                        n_count = cnt1[CW-1:0];
                        if (cnt1_ext >= 17'(HEADER_BYTES)) begin
                            if (total > 17'(BUFFER_BYTES)) begin
                                n_count = '0;
                                ev      = EV_OVERFLOW;
                            end else if (cnt1_ext == total) begin
                                n_count = '0;
                                if (i_rx_byte != r_close_byte) begin
                                    ev = EV_BAD_END;
                                end else begin
                                    n_dlen = n_decl[CW-1:0];
                                    n_new  = 1'b1;
                                    n_bank = ~r_bank;
                                    ev     = EV_ACCEPTED;
                                end
                            end
                        end
                    end
                end
                ACT_READ: begin
                    hit = idx_ext < dlen_ext;
                end
                ACT_CLEAR: begin
                    n_new = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Receive bank is written; the other bank holds the delivered frame.
    assign o_wr_data = i_rx_byte;
    assign o_wr_addr = (r_bank ? AW'(BUFFER_BYTES) : AW'(0)) + AW'(r_count);
    assign o_rd_en   = hit;
    assign o_rd_addr = (r_bank ? AW'(0) : AW'(BUFFER_BYTES)) + AW'(HEADER_BYTES)
                     + AW'(i_read_index);

    logic [CW+7:0] dlen_wide;
    assign dlen_wide = {8'd0, n_dlen};

    assign o_meta.event_res      = ev;
    assign o_meta.frame_ready    = n_new;
    assign o_meta.payload_length = dlen_wide[7:0];
    assign o_meta.read_hit       = hit;

endmodule

FILE: hdl/binary_frame_receiver_core.sv
// Top level of the binary frame receiver: request pipeline around the frame store.
//
// Usage: each input request carries an action with its receive byte and read
// index. Action receive feeds one byte of a stream framed as start flag, two
// length bytes (low byte first), payload and end flag; action read returns a
// byte of the delivered payload; action clear drops the new-frame flag.
// Every request gives exactly one result request with the event code, the
// new-frame flag, the delivered payload length and the read byte.
// The input and output channels use valid and stall; a request moves at an
// edge where valid is high and stall is low. The configuration channel uses
// valid and ready, is always ready, and holds the start flag (index 0) and
// the end flag (index 1); other indexes are ignored.
// From acceptance a request passes the stage-one register, where the registered
// frame store read completes, and then the output register. One request is taken
// every cycle while the input is not stalled; the frame store has one write
// port and one read port, so a receive and a read never compete.
// When the receiver stalls, the output register holds its result and the
// pipeline stage behind it holds too; the input stalls only when both are full.
// Synchronous reset clears the flags, counters, bank select and valid bits;
// the frame store needs no clearing since only written bytes are ever read.
module binary_frame_receiver_core #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_res,
    output logic       o_frame_ready,
    output logic [7:0] o_payload_length,
    output logic [7:0] o_read_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import bfr_pkg::*;

    localparam int AW = $clog2(2 * BUFFER_BYTES);

    logic          in_accept;
    logic          out_free;
    logic          s1_move;
    t_meta         meta;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Stage one: the request waits here while the frame store read completes.
    logic  r_s1_vld;
    t_meta r_s1_meta;

    // Output register.
    logic       r_out_vld;
    logic [2:0] r_event_res;
    logic       r_frame_ready;
    logic [7:0] r_payload_length;
    logic [7:0] r_read_data;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    bfr_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .i_read_index(i_read_index),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_meta      (meta),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    // Two banks of the frame store in one memory. A read always targets the
    // delivered bank, written at earlier edges, so no forwarding is needed.
    // The read data register only loads on a read and so holds while stalled.
    bfr_ram #(
        .WIDTH(8),
        .DEPTH(2 * BUFFER_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_meta <= meta;
        end
        if (s1_move) begin
            r_event_res      <= r_s1_meta.event_res;
            r_frame_ready    <= r_s1_meta.frame_ready;
            r_payload_length <= r_s1_meta.payload_length;
            r_read_data      <= r_s1_meta.read_hit ? rd_data : 8'd0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_event_res      = r_event_res;
    assign o_frame_ready    = r_frame_ready;
    assign o_payload_length = r_payload_length;
    assign o_read_data      = r_read_data;

endmodule

FILE: hdl/bfr_checker.sv
// Port-level assertions for the binary frame receiver, bound to the top level.
module bfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_event_res,
    input logic       o_frame_ready,
    input logic [7:0] o_read_data
);
    import bfr_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_event_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res <= EV_OVERFLOW))
        else $error("event code out of range");

    a_accept_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res == EV_ACCEPTED) |-> o_frame_ready)
        else $error("accepted frame without frame ready");

    a_event_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_NONE) |-> (o_read_data == 8'd0))
        else $error("read data on a receive result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_event_res)
            && $stable(o_read_data)))
        else $error("stalled result changed");

endmodule

bind binary_frame_receiver_core bfr_checker u_bfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_event_res  (o_event_res),
    .o_frame_ready(o_frame_ready),
    .o_read_data  (o_read_data)
);
